// ----- design/lctw_pkg.sv -----
// Package for the load cell tare and weigh block: result kinds, phases and
// sequencer states. No dependencies.
package lctw_pkg;

    typedef enum logic [1:0] {
        KIND_OFFSET = 2'd0,
        KIND_WEIGHT = 2'd1,
        KIND_FAIL   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_COLLECT = 2'd0,
        PH_WEIGH   = 2'd1,
        PH_FAIL    = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN,
        ST_BAND,
        ST_BAND_LAST,
        ST_AVG,
        ST_WDIV,
        ST_OUT
    } state_t;

    localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd0;
    localparam logic [1:0] CFG_SPREAD       = 2'd1;
    localparam logic [1:0] CFG_SCALE        = 2'd2;

    // divider width: covers a 32-bit reading sum over 1024 samples
    localparam int DIV_W = 44;

    // request to the shared unsigned divider
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

endpackage

// ----- design/lctw_ram.sv -----
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module lctw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/lctw_div.sv -----
// Restoring bit-serial unsigned divider, one quotient bit a cycle.
// Depends on lctw_pkg.
module lctw_div
    import lctw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int W = DIV_W;

    logic [W-1:0]         q_reg, q_next;
    logic [W-1:0]         r_reg, r_next;
    logic [W-1:0]         d_reg, d_next;
    logic [$clog2(W+1)-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [W:0]           trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[W-1]};
        if (req.start)
        begin
            q_next    = req.dividend;
            r_next    = '0;
            d_next    = req.divisor;
            cnt_next  = ($clog2(W+1))'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract if it fits
            if (trial >= {1'b0, d_reg})
            begin
                trial  = trial - {1'b0, d_reg};
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[W-2:0], 1'b0};
            end
            r_next   = trial[W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ($clog2(W+1))'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- design/load_cell_tare_and_weigh.sv -----
// Top level of the load cell tare and weigh block: sample memory, band pass
// and shared divider. Depends on lctw_pkg, lctw_ram and lctw_div.
//
// Usage
//   Input channel: spi_bytes with in_valid / in_stall. Each beat carries six
//   serial bytes that are unpacked into a 24-bit reading.
//   Output channel: result_kind, value, band_count with out_valid / out_stall.
//   Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; write
//   only while the block is idle. cfg_ready is always high.
//   During tare each beat is stored in the sample memory and gives no
//   result; the next beat can follow in the next cycle. The last tare beat
//   starts a mean division, a pass over the memory (one entry a cycle) and
//   a band average division that gives the offset (up to 64 readings are
//   stored); an empty band gives a failure at the end of the pass. After
//   tare a weighing beat gives its result from one division, and the next
//   beat is taken only once that result has left; the divider, one quotient
//   bit a cycle, sets the pace. Zero scale and the failed phase answer in
//   the cycle after acceptance. One item is in work at a time; in_stall is
//   high from the acceptance of a beat that gives a result until that
//   result is taken. A stalled result holds in the output register.
//   Reset clears the stored count, sum, offset and phase and restores the
//   register defaults; the sample memory needs no clearing.
module load_cell_tare_and_weigh
    import lctw_pkg::*;
#(
    parameter int MAX_SAMPLES  = 64,
    parameter int READING_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [47:0] spi_bytes,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic signed [24:0] value,
    output logic [6:0]  band_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = READING_BITS + CW;

    logic [6:0]  sample_count_reg;
    logic [6:0]  spread_reg;
    logic signed [15:0] scale_reg;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic [CW-1:0] stored_reg, stored_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic [SW-1:0] bsum_reg, bsum_next;
    logic [CW-1:0] bcnt_reg, bcnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [READING_BITS-1:0] offset_reg, offset_next;
    logic [DIV_W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic        neg_reg, neg_next;
    logic        ovalid_reg, ovalid_next;
    kind_t       okind_reg, okind_next;
    logic [24:0] oval_reg, oval_next;
    logic [6:0]  ocnt_reg, ocnt_next;
    logic        mean_wait_reg, mean_wait_next;

    logic [23:0] unpacked;
    logic [READING_BITS-1:0] reading_in;
    logic        accept;
    logic [CW-1:0] n_eff;
    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [READING_BITS-1:0] mem_rdata;
    div_req_t    dreq;
    logic        ddone;
    logic [DIV_W-1:0] dq;
    logic [DIV_W-1:0] s200;
    logic [8:0]  lo_fac, hi_fac;
    logic [15:0] scale_mag;

    function automatic logic [READING_BITS:0] diff_mag_in(
        input logic [READING_BITS-1:0] a,
        input logic [READING_BITS-1:0] b
    );
        diff_mag_in = (a >= b) ? {1'b0, a - b} : {1'b0, b - a};
    endfunction

    // bits 6,4,2,0 of each byte, first byte most significant
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                unpacked[23 - 4*i - j] = spi_bytes[47 - 8*i - 1 - 2*j];
            end
        end
    end
    assign reading_in = READING_BITS'(unpacked);

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE) || ovalid_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (sample_count_reg == 7'd0)
            n_eff = CW'(1);
        else if ({25'd0, sample_count_reg} > 32'(MAX_SAMPLES))
            n_eff = CW'(MAX_SAMPLES);
        else
            n_eff = CW'(sample_count_reg);
    end

    assign mem_we    = accept && (phase_reg == PH_COLLECT)
                       && (stored_reg < CW'(MAX_SAMPLES));
    assign mem_waddr = stored_reg[AW-1:0];
    assign mem_raddr = idx_reg[AW-1:0];

    lctw_ram #(.WIDTH(READING_BITS), .DEPTH(MAX_SAMPLES), .AW(AW)) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (reading_in),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lctw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (dreq),
        .done     (ddone),
        .quotient (dq)
    );

    assign s200      = DIV_W'(mem_rdata) * DIV_W'(200);
    assign lo_fac    = 9'd200 - {2'b00, spread_reg};
    assign hi_fac    = 9'd200 + {2'b00, spread_reg};
    assign scale_mag = scale_reg[15] ? 16'(-scale_reg) : 16'(scale_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= 7'd50;
            spread_reg       <= 7'd1;
            scale_reg        <= -16'sd142;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SAMPLE_COUNT: sample_count_reg <= cfg_data[6:0];
                CFG_SPREAD:       spread_reg       <= cfg_data[6:0];
                CFG_SCALE:        scale_reg        <= cfg_data;
                default:          ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (phase_reg == PH_COLLECT)
                    begin
                        if (stored_next >= n_eff)
                            state_next = ST_MEAN;
                    end
                    else if (phase_reg == PH_WEIGH && scale_reg != 16'sd0)
                        state_next = ST_WDIV;
                end
            end
            ST_MEAN:
            begin
                // a single stored reading goes straight to the last band step
                if (ddone)
                    state_next = (stored_reg == CW'(1)) ? ST_BAND_LAST : ST_BAND;
            end
            ST_BAND:
            begin
                if (idx_reg + 1'b1 >= stored_reg)
                    state_next = ST_BAND_LAST;
            end
            ST_BAND_LAST: state_next = (bcnt_next == '0) ? ST_IDLE : ST_AVG;
            ST_AVG:       if (ddone && !mean_wait_reg) state_next = ST_IDLE;
            ST_WDIV:      if (ddone && !mean_wait_reg) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        phase_next     = phase_reg;
        stored_next    = stored_reg;
        sum_next       = sum_reg;
        bsum_next      = bsum_reg;
        bcnt_next      = bcnt_reg;
        idx_next       = idx_reg;
        offset_next    = offset_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        neg_next       = neg_reg;
        mean_wait_next = 1'b0;
        ovalid_next    = ovalid_reg && out_stall;
        okind_next     = okind_reg;
        oval_next      = oval_reg;
        ocnt_next      = ocnt_reg;
        dreq           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (phase_reg == PH_COLLECT)
                    begin
                        if (stored_reg < CW'(MAX_SAMPLES))
                        begin
                            stored_next = stored_reg + 1'b1;
                            sum_next    = sum_reg + SW'(reading_in);
                        end
                        if (stored_next >= n_eff)
                        begin
                            dreq.start    = 1'b1;
                            dreq.dividend = DIV_W'(sum_next);
                            dreq.divisor  = DIV_W'(stored_next);
                        end
                    end
                    else if (phase_reg == PH_WEIGH)
                    begin
                        if (scale_reg == 16'sd0)
                        begin
                            ovalid_next = 1'b1;
                            okind_next  = KIND_WEIGHT;
                            oval_next   = '0;
                            ocnt_next   = '0;
                        end
                        else
                        begin
                            mean_wait_next = 1'b1;
                            dreq.start     = 1'b1;
                            dreq.dividend  = DIV_W'(diff_mag_in(reading_in, offset_reg));
                            dreq.divisor   = DIV_W'(scale_mag);
                            neg_next       = (reading_in < offset_reg) ^ scale_reg[15];
                        end
                    end
                    else
                    begin
                        ovalid_next = 1'b1;
                        okind_next  = KIND_FAIL;
                        oval_next   = '0;
                        ocnt_next   = '0;
                    end
                end
            end
            ST_MEAN:
            begin
                idx_next  = '0;
                bsum_next = '0;
                bcnt_next = '0;
                if (ddone)
                begin
                    // the mean never exceeds a reading
                    lo_next  = DIV_W'(dq[READING_BITS-1:0]) * DIV_W'(lo_fac);
                    hi_next  = DIV_W'(dq[READING_BITS-1:0]) * DIV_W'(hi_fac);
                    idx_next = CW'(1);
                end
            end
            ST_BAND, ST_BAND_LAST:
            begin
                // rdata is the entry addressed last cycle
                if (s200 > lo_reg && s200 < hi_reg)
                begin
                    bsum_next = bsum_reg + SW'(mem_rdata);
                    bcnt_next = bcnt_reg + 1'b1;
                end
                if (state_reg == ST_BAND)
                    idx_next = idx_reg + 1'b1;
                else
                begin
                    if (bcnt_next == '0)
                    begin
                        phase_next  = PH_FAIL;
                        ovalid_next = 1'b1;
                        okind_next  = KIND_FAIL;
                        oval_next   = '0;
                        ocnt_next   = '0;
                    end
                    else
                    begin
                        mean_wait_next = 1'b1;
                        dreq.start     = 1'b1;
                        dreq.dividend  = DIV_W'(bsum_next);
                        dreq.divisor   = DIV_W'(bcnt_next);
                    end
                end
            end
            ST_AVG:
            begin
                if (ddone && !mean_wait_reg)
                begin
                    offset_next = READING_BITS'(dq);
                    phase_next  = PH_WEIGH;
                    ovalid_next = 1'b1;
                    okind_next  = KIND_OFFSET;
                    oval_next   = 25'(dq[READING_BITS-1:0]);
                    ocnt_next   = 7'(bcnt_reg);
                end
            end
            ST_WDIV:
            begin
                if (ddone && !mean_wait_reg)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = KIND_WEIGHT;
                    oval_next   = neg_reg ? 25'(-dq[24:0]) : dq[24:0];
                    ocnt_next   = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_COLLECT;
            stored_reg    <= '0;
            sum_reg       <= '0;
            offset_reg    <= '0;
            ovalid_reg    <= 1'b0;
            mean_wait_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            stored_reg    <= stored_next;
            sum_reg       <= sum_next;
            offset_reg    <= offset_next;
            ovalid_reg    <= ovalid_next;
            mean_wait_reg <= mean_wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bsum_reg    <= bsum_next;
        bcnt_reg    <= bcnt_next;
        idx_reg     <= idx_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        neg_reg     <= neg_next;
        okind_reg   <= okind_next;
        oval_reg    <= oval_next;
        ocnt_reg    <= ocnt_next;
    end

    assign out_valid   = ovalid_reg;
    assign result_kind = okind_reg;
    assign value       = oval_reg;
    assign band_count  = ocnt_reg;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value))
        else $error("result dropped while stalled");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> in_stall)
        else $error("input taken while busy");

    a_fail_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FAIL |=> phase_reg == PH_FAIL)
        else $error("left failed phase");

endmodule

// ----- tb/load_cell_tare_and_weigh_test.sv -----
// Testbench for load_cell_tare_and_weigh: tare with a lowered sample count,
// directed and random weighing across scale settings. Depends on lctw_pkg.
`timescale 1ns / 100ps

module load_cell_tare_and_weigh_test;
    import lctw_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic [1:0]         kind;
        logic signed [24:0] amount;
        logic [6:0]         cnt;
    } weighing_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [47:0]        spi_bytes = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         result_kind;
    logic signed [24:0] value;
    logic [6:0]         band_count;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;

    // predictor state
    logic [23:0]     tare_readings [64];
    int unsigned     readings_held;
    phase_t          tare_phase;
    longint unsigned reading_total;
    logic [23:0]     zero_offset;
    logic [6:0]      count_setting;
    logic [6:0]      spread_setting;
    logic [15:0]     divisor_setting;

    logic [47:0] pending_beats [$];
    weighing_t   expected_results [$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        hold_request = 1'b0;
    int          hold_left = 0;
    int          mismatches = 0;
    int          beats_sent = 0;
    int          results_seen = 0;
    int          cycle_count = 0;
    int          offsets_seen = 0;

    load_cell_tare_and_weigh i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .spi_bytes  (spi_bytes),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result_kind(result_kind),
        .value      (value),
        .band_count (band_count),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [23:0] unpack_reading(logic [47:0] b);
        logic [23:0] r;
        r = '0;
        for (int i = 0; i < 6; i++)
            for (int j = 6; j >= 0; j -= 2)
                r = {r[22:0], b[40 - 8 * i + j]};
        return r;
    endfunction

    // place reading bits on the even positions, odd positions keep the filler
    function automatic logic [47:0] pack_reading(logic [23:0] r, logic [47:0] filler);
        logic [47:0] b;
        b = filler;
        for (int i = 0; i < 6; i++)
            for (int k = 0; k < 4; k++)
                b[40 - 8 * i + 6 - 2 * k] = r[23 - (4 * i + k)];
        return b;
    endfunction

    function automatic logic [47:0] random_filler();
        return {$urandom, $urandom};
    endfunction

    function automatic void predict_weighing(logic [47:0] b);
        logic [23:0]     reading;
        int unsigned     n;
        int unsigned     in_band;
        longint unsigned mean, lo, hi, band_total, scaled;
        longint          divisor, diff;
        weighing_t       res;
        reading = unpack_reading(b);
        res.cnt = '0;
        res.amount = '0;
        if (tare_phase == PH_COLLECT)
        begin
            n = count_setting;
            if (n < 1) n = 1;
            if (n > 64) n = 64;
            if (readings_held < 64)
            begin
                tare_readings[readings_held] = reading;
                readings_held++;
                reading_total += reading;
            end
            if (readings_held < n) return;
            mean = reading_total / readings_held;
            lo = mean * (200 - spread_setting);
            hi = mean * (200 + spread_setting);
            band_total = 0;
            in_band = 0;
            for (int i = 0; i < readings_held; i++)
            begin
                scaled = longint'(tare_readings[i]) * 200;
                if (scaled > lo && scaled < hi)
                begin
                    band_total += tare_readings[i];
                    in_band++;
                end
            end
            if (in_band == 0)
            begin
                tare_phase = PH_FAIL;
                res.kind = KIND_FAIL;
            end
            else
            begin
                zero_offset = 24'(band_total / in_band);
                tare_phase = PH_WEIGH;
                res.kind = KIND_OFFSET;
                res.amount = 25'(zero_offset);
                res.cnt = 7'(in_band);
            end
        end
        else if (tare_phase == PH_WEIGH)
        begin
            divisor = longint'($signed(divisor_setting));
            diff = longint'(reading) - longint'(zero_offset);
            res.kind = KIND_WEIGHT;
            res.amount = (divisor == 0) ? 25'sd0 : 25'(diff / divisor);
        end
        else
        begin
            res.kind = KIND_FAIL;
        end
        expected_results.push_back(res);
    endfunction

    // driver: hold a stalled beat, otherwise offer the next pending one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_weighing(spi_bytes);
                beats_sent++;
            end
            if (in_valid && in_stall)
            begin
                in_valid <= 1'b1;
            end
            else if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid  <= 1'b1;
                spi_bytes <= pending_beats.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_request)
            hold_left <= 400;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // monitor: check each result beat against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: kind %0d value %0d band %0d",
                                 result_kind, value, band_count);
                end
                else
                begin
                    weighing_t want;
                    want = expected_results.pop_front();
                    if (want.kind == KIND_OFFSET) offsets_seen++;
                    if (result_kind !== want.kind || value !== want.amount
                        || band_count !== want.cnt)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected kind %0d value %0d band %0d,",
                                      " got kind %0d value %0d band %0d"},
                                     want.kind, want.amount, want.cnt,
                                     result_kind, value, band_count);
                    end
                end
            end
            out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic write_register(logic [1:0] idx, logic [15:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SAMPLE_COUNT: count_setting = data[6:0];
            CFG_SPREAD:       spread_setting = data[6:0];
            CFG_SCALE:        divisor_setting = data;
            default: ;
        endcase
    endtask

    // pause the sender until every expected result is back and the block is quiet
    task automatic drain_block();
        while (pending_beats.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_weighings(int count);
        logic [23:0] r;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 60)
                r = zero_offset + 24'($urandom_range(20000)) - 24'd10000;
            else
                r = 24'($urandom);
            if ($urandom_range(99) < 15)
                pending_beats.push_back(random_filler());
            else
                pending_beats.push_back(pack_reading(r, random_filler()));
        end
    endtask

    function automatic logic [15:0] random_divisor();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'h8000;
            2: return 16'h7FFF;
            3: return 16'hFFFF;
            4: return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [15:0] extremes [6];
        tare_phase = PH_COLLECT;
        readings_held = 0;
        reading_total = 0;
        zero_offset = '0;
        count_setting = 7'd50;
        spread_setting = 7'd1;
        divisor_setting = 16'hFF72;
        extremes = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFF72};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 35;
        recv_idle_pct = 55;

        // tare: start with the largest count, then lower it mid-way
        write_register(CFG_SPREAD, 16'd100);
        write_register(CFG_SAMPLE_COUNT, 16'd64);
        pending_beats.push_back(48'h0);
        pending_beats.push_back(48'hFFFF_FFFF_FFFF);
        pending_beats.push_back(pack_reading(24'h800000, 48'hAAAA_AAAA_AAAA));
        drain_block();
        write_register(CFG_SAMPLE_COUNT, 16'd2);
        pending_beats.push_back(pack_reading(24'h900000, 48'h0));
        drain_block();

        // tare registers no longer matter, but take their extremes anyway
        write_register(CFG_SAMPLE_COUNT, 16'd0);
        write_register(CFG_SPREAD, 16'd0);
        write_register(CFG_SAMPLE_COUNT, 16'd127);
        write_register(CFG_SPREAD, 16'd127);

        // directed weighing: extreme and offset readings against extreme divisors
        foreach (extremes[k])
        begin
            write_register(CFG_SCALE, extremes[k]);
            pending_beats.push_back(48'h0);
            pending_beats.push_back(48'hFFFF_FFFF_FFFF);
            pending_beats.push_back(pack_reading(zero_offset, random_filler()));
            drain_block();
        end

        // random weighing in three idling modes, long receiver hold-off in the first
        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 35 : (mode == 1) ? 55 : 0;
            recv_idle_pct = (mode == 0) ? 55 : (mode == 1) ? 35 : 0;
            for (int seg = 0; seg < 8; seg++)
            begin
                write_register(CFG_SCALE, random_divisor());
                queue_weighings(50);
                if (mode == 0 && seg == 1)
                begin
                    @(posedge clk);
                    hold_request <= 1'b1;
                    @(posedge clk);
                    hold_request <= 1'b0;
                end
                drain_block();
            end
        end

        $display("run covered %0d input beats and %0d result beats (%0d tare offsets)",
                 beats_sent, results_seen, offsets_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
